@@ rtl/point_cloud_nearest_distance_core_macros.svh @@
// assertion macros for the point cloud nearest distance core
`ifndef POINT_CLOUD_NEAREST_DISTANCE_CORE_MACROS_SVH
`define POINT_CLOUD_NEAREST_DISTANCE_CORE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PCND_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define PCND_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pcnd_pkg.sv @@
// shared types and codes of the point cloud nearest distance core
`default_nettype none
package pcnd_pkg;

    localparam int COORD_W = 20;
    localparam int DIST_W  = 43;
    localparam int VAL_W   = 46;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;
    localparam int POINT_W = 3 * COORD_W;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] MODE_MEAN = 2'd0;
    localparam logic [1:0] MODE_MAX  = 2'd1;
    localparam logic [1:0] MODE_ROOT = 2'd2;

    localparam logic CFG_MODE      = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_store;
        logic query_take;
        logic noref_set;
        logic scan_start;
        logic scan_issue;
        logic fold;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic store_full;
        logic scan_last;
        logic pipe_empty;
        logic last_q;
        logic div_last;
        logic sqrt_last;
        logic mode_root;
    } stat_t;

endpackage
`default_nettype wire

@@ rtl/pcnd_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module pcnd_ram #(
    parameter int WIDTH  = 60,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/pcnd_ctrl.sv @@
// control state machine of the point cloud nearest distance core
`default_nettype none
module pcnd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    req_type,
    input  wire logic          last_query,
    input  wire pcnd_pkg::stat_t stat,
    output pcnd_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               done
);
    import pcnd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_DRAIN   = 8'b0000_0100,
        S_DIV_LD  = 8'b0000_1000,
        S_DIV     = 8'b0001_0000,
        S_ROOT_LD = 8'b0010_0000,
        S_ROOT    = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_LOAD:  cmd.load = 1'b1;
                        REQ_CLEAR: cmd.clear_store = 1'b1;
                        REQ_QUERY:
                        begin
                            cmd.query_take = 1'b1;
                            if (stat.count_zero)
                            begin
                                cmd.noref_set = 1'b1;
                                if (last_query)
                                begin
                                    state_next = S_DIV_LD;
                                end
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.fold   = 1'b1;
                    state_next = stat.last_q ? S_DIV_LD : S_IDLE;
                end
            end
            S_DIV_LD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = stat.mode_root ? S_ROOT_LD : S_OUT;
                end
            end
            S_ROOT_LD:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule
`default_nettype wire

@@ rtl/pcnd_datapath.sv @@
// store, distance pipeline, accumulators, divider and square root
`default_nettype none
module pcnd_datapath #(
    parameter int REF_DEPTH = 1024,
    parameter int ADDR_W    = 10,
    parameter int COUNT_W   = 11
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pcnd_pkg::cmd_t               cmd,
    output pcnd_pkg::stat_t                   stat,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [pcnd_pkg::VAL_W-1:0]   cfg_wdata,
    input  wire logic signed [pcnd_pkg::COORD_W-1:0] x_coord,
    input  wire logic signed [pcnd_pkg::COORD_W-1:0] y_coord,
    input  wire logic signed [pcnd_pkg::COORD_W-1:0] z_coord,
    input  wire logic                         last_query,
    output logic [pcnd_pkg::VAL_W-1:0]        distance_value,
    output logic [pcnd_pkg::CNT_W-1:0]        matched_count,
    output logic                              no_reference,
    output logic                              store_overflow
);
    import pcnd_pkg::*;

    localparam int ROOT_W = VAL_W / 2;

    logic [1:0]         mode_reg;
    logic [VAL_W-1:0]   thr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;
    logic               noref_reg;
    logic               last_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic [3:0]         vld_reg;
    logic signed [COORD_W:0] dx_reg, dy_reg, dz_reg;
    logic [2*COORD_W:0] sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   match_reg;
    logic [DIST_W-1:0]  largest_reg;
    logic [CNT_W-1:0]   div_rem_reg;
    logic [SUM_W-1:0]   div_quo_reg;
    logic [CNT_W-1:0]   divisor_reg;
    logic [5:0]         div_cnt_reg;
    logic [VAL_W-1:0]   sq_src_reg;
    logic [ROOT_W+1:0]  sq_rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [4:0]         sq_cnt_reg;

    logic [POINT_W-1:0] rdata;
    logic [COUNT_W-1:0] count_m1;
    logic [VAL_W-1:0]   mean;
    logic [SUM_W:0]     sum_ext;
    logic [CNT_W:0]     div_tmp;
    logic [ROOT_W+1:0]  sq_tmp;
    logic [ROOT_W+1:0]  sq_trial;
    logic signed [2*COORD_W+1:0] px_full, py_full, pz_full;

    // reference point store
    pcnd_ram #(
        .WIDTH  (POINT_W),
        .DEPTH  (REF_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load && !stat.store_full),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({x_coord, y_coord, z_coord}),
        .raddr (scan_addr_reg),
        .rdata (rdata)
    );

    // status toward the controller
    assign count_m1        = count_reg - 1'b1;
    assign stat.count_zero = (count_reg == '0);
    assign stat.store_full = (count_reg == COUNT_W'(REF_DEPTH));
    assign stat.scan_last  = (scan_addr_reg == count_m1[ADDR_W-1:0]);
    assign stat.pipe_empty = (vld_reg == '0);
    assign stat.last_q     = last_reg;
    assign stat.div_last   = (div_cnt_reg == 6'd63);
    assign stat.sqrt_last  = (sq_cnt_reg == 5'(ROOT_W - 1));
    assign stat.mode_root  = (mode_reg == MODE_ROOT);

    // configuration, store count and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MEAN;
            thr_reg   <= '1;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            noref_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODE:      mode_reg <= cfg_wdata[1:0];
                    CFG_THRESHOLD: thr_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                if (stat.store_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.clear_store)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.query_take)
            begin
                last_reg <= last_query;
            end
            if (cmd.noref_set)
            begin
                noref_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                noref_reg <= 1'b0;
            end
        end
    end

    // query point latch
    always_ff @(posedge clk)
    begin
        if (cmd.query_take)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
            pz_reg <= z_coord;
        end
    end

    // scan address and stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            vld_reg       <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], cmd.scan_issue};
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
        end
    end

    // distance pipeline: difference, square, sum, minimum
    assign px_full = dx_reg * dx_reg;
    assign py_full = dy_reg * dy_reg;
    assign pz_full = dz_reg * dz_reg;

    always_ff @(posedge clk)
    begin
        dx_reg   <= (COORD_W+1)'(px_reg) - (COORD_W+1)'($signed(rdata[3*COORD_W-1:2*COORD_W]));
        dy_reg   <= (COORD_W+1)'(py_reg) - (COORD_W+1)'($signed(rdata[2*COORD_W-1:COORD_W]));
        dz_reg   <= (COORD_W+1)'(pz_reg) - (COORD_W+1)'($signed(rdata[COORD_W-1:0]));
        sx_reg   <= px_full[2*COORD_W:0];
        sy_reg   <= py_full[2*COORD_W:0];
        sz_reg   <= pz_full[2*COORD_W:0];
        dist_reg <= DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
        if (cmd.scan_start)
        begin
            best_reg <= '1;
        end
        else if (vld_reg[3] && dist_reg < best_reg)
        begin
            best_reg <= dist_reg;
        end
    end

    // query accumulators
    assign sum_ext = {1'b0, sum_reg} + (SUM_W+1)'(best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            match_reg   <= '0;
            largest_reg <= '0;
        end
        else if (cmd.emit)
        begin
            sum_reg     <= '0;
            match_reg   <= '0;
            largest_reg <= '0;
        end
        else if (cmd.fold && (VAL_W'(best_reg) < thr_reg))
        begin
            sum_reg <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (match_reg != '1)
            begin
                match_reg <= match_reg + 1'b1;
            end
            if (best_reg > largest_reg)
            begin
                largest_reg <= best_reg;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign div_tmp = {div_rem_reg, div_quo_reg[SUM_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= sum_reg;
            divisor_reg <= match_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_tmp >= {1'b0, divisor_reg})
            begin
                div_rem_reg <= CNT_W'(div_tmp - {1'b0, divisor_reg});
                div_quo_reg <= {div_quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_tmp[CNT_W-1:0];
                div_quo_reg <= {div_quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // saturated mean, zero when nothing was kept
    always_comb
    begin
        if (match_reg == '0)
        begin
            mean = '0;
        end
        else if (div_quo_reg[SUM_W-1:VAL_W] != '0)
        begin
            mean = '1;
        end
        else
        begin
            mean = div_quo_reg[VAL_W-1:0];
        end
    end

    // digit by digit square root, two bits a cycle
    assign sq_tmp   = {sq_rem_reg[ROOT_W-1:0], sq_src_reg[VAL_W-1:VAL_W-2]};
    assign sq_trial = {root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_src_reg <= mean;
            sq_rem_reg <= '0;
            root_reg   <= '0;
            sq_cnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
            sq_src_reg <= {sq_src_reg[VAL_W-3:0], 2'b00};
            if (sq_tmp >= sq_trial)
            begin
                sq_rem_reg <= sq_tmp - sq_trial;
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg <= sq_tmp;
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // result selection
    always_comb
    begin
        case (mode_reg)
            MODE_MEAN: distance_value = mean;
            MODE_MAX:  distance_value = VAL_W'(largest_reg);
            MODE_ROOT: distance_value = VAL_W'(root_reg);
            default:   distance_value = '0;
        endcase
    end

    assign matched_count  = match_reg;
    assign no_reference   = noref_reg;
    assign store_overflow = ovf_reg;

endmodule
`default_nettype wire

@@ rtl/point_cloud_nearest_distance_core.sv @@
// load/clear requests are taken in idle; a query scans each of the n stored points
// a last query then runs the 64-step divider, and in root mode the 23-step root
// one request at a time: start is taken only while the controller is idle
// the result strobe done lasts one cycle and cannot be stalled by the receiver
// rst_n at once clears the store count, flags, accumulators and control state
`default_nettype none
`include "point_cloud_nearest_distance_core_macros.svh"
module point_cloud_nearest_distance_core #(
    parameter int REF_DEPTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   req_type,
    input  wire logic signed [pcnd_pkg::COORD_W-1:0] x_coord,
    input  wire logic signed [pcnd_pkg::COORD_W-1:0] y_coord,
    input  wire logic signed [pcnd_pkg::COORD_W-1:0] z_coord,
    input  wire logic                         last_query,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [pcnd_pkg::VAL_W-1:0]   cfg_wdata,
    output logic                              done,
    output logic [pcnd_pkg::VAL_W-1:0]        distance_value,
    output logic [pcnd_pkg::CNT_W-1:0]        matched_count,
    output logic                              no_reference,
    output logic                              store_overflow
);
    import pcnd_pkg::*;

    localparam int ADDR_W  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int COUNT_W = $clog2(REF_DEPTH + 1);

    cmd_t  cmd;
    stat_t stat;

    // controller
    pcnd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .last_query (last_query),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    // datapath
    pcnd_datapath #(
        .REF_DEPTH (REF_DEPTH),
        .ADDR_W    (ADDR_W),
        .COUNT_W   (COUNT_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .z_coord        (z_coord),
        .last_query     (last_query),
        .distance_value (distance_value),
        .matched_count  (matched_count),
        .no_reference   (no_reference),
        .store_overflow (store_overflow)
    );

    // checks
    `PCND_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe held two cycles")
    `PCND_ASSERT_NOW(a_ovf_full, store_overflow, stat.store_full, "overflow flag with store not full")
    `PCND_ASSERT_NOW(a_done_busy, done, busy && !cmd.load, "result strobe while idle")
    `PCND_ASSERT_NEXT(a_scan_busy, cmd.scan_start, busy && cmd.scan_issue, "scan did not start")

endmodule
`default_nettype wire
